FILE: sv/wsc_pkg.sv
// Shared constants, codes and helper functions for the waypoint steering controller.
// Used by wsc_cordic and waypoint_steering_controller_top; depends on nothing else.
package wsc_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CNT_W = 5;           // iteration counter, covers up to 24 steps
    localparam int CW = 44;             // CORDIC x and y datapath width
    localparam int ZW = 34;             // CORDIC angle accumulator width, Q30

    localparam logic signed [17:0] PI_Q13 = 18'sd25736;
    localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;
    localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;
    localparam logic signed [15:0] PI_Q13_16 = 16'sd25736;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [31:0] INV_GAIN_Q30 = 32'sd652032874;

    // Input command codes.
    localparam logic [2:0] CMD_POSE = 3'd0;
    localparam logic [2:0] CMD_GOAL = 3'd1;
    localparam logic [2:0] CMD_AVOID = 3'd2;
    localparam logic [2:0] CMD_SUPER = 3'd3;
    localparam logic [2:0] CMD_INTR = 3'd4;
    localparam logic [2:0] CMD_TICK = 3'd5;

    // Result kinds.
    localparam logic [1:0] KIND_STOP = 2'd0;
    localparam logic [1:0] KIND_GOING = 2'd1;
    localparam logic [1:0] KIND_ARRIVED = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_CRUISE = 3'd0;
    localparam logic [2:0] CFG_RADIUS = 3'd1;
    localparam logic [2:0] CFG_TOL = 3'd2;
    localparam logic [2:0] CFG_SPIN = 3'd3;
    localparam logic [2:0] CFG_GAIN = 3'd4;
    localparam logic [2:0] CFG_AVMIN = 3'd5;
    localparam logic [2:0] CFG_TRAV = 3'd6;

    typedef struct packed {
        logic start;
        logic rotate;
    } cord_req_t;

    function automatic logic signed [ZW-1:0] atan_q30(input logic [CNT_W-1:0] i);
        logic signed [ZW-1:0] r;
        case (i)
            5'd0: r = 34'sd843314857;
            5'd1: r = 34'sd497837829;
            5'd2: r = 34'sd263043837;
            5'd3: r = 34'sd133525159;
            5'd4: r = 34'sd67021687;
            5'd5: r = 34'sd33543516;
            5'd6: r = 34'sd16775851;
            5'd7: r = 34'sd8388437;
            5'd8: r = 34'sd4194283;
            5'd9: r = 34'sd2097149;
            5'd10: r = 34'sd1048576;
            5'd11: r = 34'sd524288;
            5'd12: r = 34'sd262144;
            5'd13: r = 34'sd131072;
            5'd14: r = 34'sd65536;
            5'd15: r = 34'sd32768;
            5'd16: r = 34'sd16384;
            5'd17: r = 34'sd8192;
            5'd18: r = 34'sd4096;
            5'd19: r = 34'sd2048;
            5'd20: r = 34'sd1024;
            5'd21: r = 34'sd512;
            5'd22: r = 34'sd256;
            5'd23: r = 34'sd128;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Right shift that rounds half away from zero.
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                     input logic [5:0] n);
        logic signed [63:0] half;
        logic signed [63:0] mag;
        half = 64'sd1 <<< (n - 6'd1);
        mag = -v;
        if (v >= 0)
            return (v + half) >>> n;
        else
            return -((mag + half) >>> n);
    endfunction

endpackage

FILE: sv/waypoint_steering_controller_top.sv
// Waypoint steering controller: top level with event handling, sequencer and shared multiplier.
// Depends on wsc_pkg and instantiates wsc_cordic.
//
// Usage: one input channel (in_valid/in_stall) carries events: pose, goal, avoidance angle,
// supervisor state, interrupt and tick. One output channel (out_valid/out_stall) carries
// drive commands. A separate configuration channel (cfg_valid/cfg_ready, always ready)
// writes the seven control registers by index; the user must use it only while the block
// is idle, which the block does not enforce. Pose, goal, avoid and supervisor events give
// no transfer. An interrupt stop goes through the emit state and raises out_valid once the
// output register is free. A tick that finds the block active with pose and goal known
// runs a sequence on one 32x32 multiplier (each product passes a multiply and an
// accumulate state, up to twelve products) and one iterative CORDIC (up to three passes,
// each vectoring pass with input normalization). The input is stalled while an item is
// in work.
// The result waits in an output register while out_stall is high; the next item is
// accepted meanwhile, and a following result waits until the register frees.
// Reset clears the control and navigation state and loads the configuration defaults.
module waypoint_steering_controller_top #(
    parameter int CORDIC_STEPS = wsc_pkg::CORDIC_STEPS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         cmd,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    input  logic signed [15:0] quat_w,
    input  logic               flag,
    input  logic signed [15:0] angle_value,
    input  logic [7:0]         state_code,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] vel_x,
    output logic signed [15:0] vel_y,
    output logic signed [15:0] turn_rate,
    output logic [1:0]         result_kind,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RCHK = 4'd1;
    localparam logic [3:0] S_MUL = 4'd2;
    localparam logic [3:0] S_ACC = 4'd3;
    localparam logic [3:0] S_START = 4'd4;
    localparam logic [3:0] S_CORD = 4'd5;
    localparam logic [3:0] S_ERR = 4'd6;
    localparam logic [3:0] S_DEC = 4'd7;
    localparam logic [3:0] S_EMIT = 4'd8;

    localparam logic [3:0] OP_AX = 4'd0;
    localparam logic [3:0] OP_AY = 4'd1;
    localparam logic [3:0] OP_RR = 4'd2;
    localparam logic [3:0] OP_QXX = 4'd3;
    localparam logic [3:0] OP_QYY = 4'd4;
    localparam logic [3:0] OP_QZZ = 4'd5;
    localparam logic [3:0] OP_QWW = 4'd6;
    localparam logic [3:0] OP_QXZ = 4'd7;
    localparam logic [3:0] OP_QWY = 4'd8;
    localparam logic [3:0] OP_QXY = 4'd9;
    localparam logic [3:0] OP_QWZ = 4'd10;
    localparam logic [3:0] OP_GAIN = 4'd11;
    localparam logic [3:0] OP_KMAG = 4'd12;

    localparam logic [1:0] JOB_YAW = 2'd0;
    localparam logic [1:0] JOB_BEAR = 2'd1;
    localparam logic [1:0] JOB_POLAR = 2'd2;

    // Configuration registers.
    logic [14:0] cruise_reg, tol_reg, spin_reg, avmin_reg;
    logic [30:0] radius_reg;
    logic [15:0] gain_reg;
    logic [7:0]  trav_reg;

    // Stored navigation state.
    logic signed [31:0] cur_x_reg, cur_y_reg, goal_x_reg, goal_y_reg;
    logic signed [15:0] qx_reg, qy_reg, qz_reg, qw_reg;
    logic signed [15:0] avoid_angle_reg;
    logic avoid_on_reg, nav_active_reg, pose_seen_reg, goal_seen_reg;

    // Sequencer and datapath.
    logic [3:0] state_reg, state_next;
    logic [3:0] op_reg;
    logic [1:0] job_reg;
    logic signed [32:0] ex_reg, ey_reg;
    logic [32:0] ax_reg, ay_reg;
    logic signed [63:0] prod_reg, acc_reg;
    logic signed [35:0] accb_reg;
    logic signed [wsc_pkg::CW-1:0] yaw_x_reg;
    logic yaw_zero_reg, flip_reg;
    logic signed [16:0] yaw_reg, bear_reg;
    logic signed [17:0] e_reg;
    logic signed [wsc_pkg::CW-1:0] cx_ld_reg, cy_ld_reg;
    logic signed [wsc_pkg::ZW-1:0] cz_ld_reg;
    logic signed [15:0] res_vx_reg, res_vy_reg, res_w_reg;
    logic [1:0] res_kind_reg;

    // Output register.
    logic out_valid_reg;
    logic signed [15:0] vel_x_reg, vel_y_reg, turn_reg;
    logic [1:0] kind_reg;

    logic accept, tick_go, out_free, rr_going, far, e_small;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] pw;
    logic [32:0] ax_w, ay_w;
    logic [36:0] g2_abs;
    logic signed [17:0] e_raw;
    logic signed [15:0] mn16, pa;
    logic signed [63:0] w_rnd, x_rnd, y_rnd;
    logic signed [17:0] tol18;

    wsc_pkg::cord_req_t cord_req;
    logic cord_done;
    logic signed [wsc_pkg::CW-1:0] cord_x, cord_y;
    logic signed [wsc_pkg::ZW-1:0] cord_z;

    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free = !out_valid_reg || !out_stall;
    assign tick_go = (cmd == wsc_pkg::CMD_TICK) && nav_active_reg && pose_seen_reg
                     && goal_seen_reg;
    assign rr_going = acc_reg > prod_reg;
    assign ax_w = ex_reg[32] ? 33'(-ex_reg) : 33'(ex_reg);
    assign ay_w = ey_reg[32] ? 33'(-ey_reg) : 33'(ey_reg);
    assign far = (ax_w > {2'b0, radius_reg}) || (ay_w > {2'b0, radius_reg});
    assign tol18 = {3'b0, tol_reg};
    assign e_small = (e_reg < tol18) && (e_reg > -tol18);
    assign g2_abs = accb_reg[35] ? {37'(-accb_reg)} << 1 : {37'(accb_reg)} << 1;
    assign e_raw = 18'(bear_reg) - 18'(yaw_reg);
    assign mn16 = {1'b0, avmin_reg};
    assign pa = avoid_angle_reg;
    assign w_rnd = wsc_pkg::rnd_shift(prod_reg, 6'd13);
    assign x_rnd = wsc_pkg::rnd_shift(64'(cord_x), 6'd16);
    assign y_rnd = wsc_pkg::rnd_shift(64'(cord_y), 6'd16);
    assign pw = 64'(prod_reg);

    // Shared multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (op_reg)
            OP_AX: begin mul_a = {1'b0, ax_reg[30:0]}; mul_b = {1'b0, ax_reg[30:0]}; end
            OP_AY: begin mul_a = {1'b0, ay_reg[30:0]}; mul_b = {1'b0, ay_reg[30:0]}; end
            OP_RR: begin mul_a = {1'b0, radius_reg}; mul_b = {1'b0, radius_reg}; end
            OP_QXX: begin mul_a = 32'(qx_reg); mul_b = 32'(qx_reg); end
            OP_QYY: begin mul_a = 32'(qy_reg); mul_b = 32'(qy_reg); end
            OP_QZZ: begin mul_a = 32'(qz_reg); mul_b = 32'(qz_reg); end
            OP_QWW: begin mul_a = 32'(qw_reg); mul_b = 32'(qw_reg); end
            OP_QXZ: begin mul_a = 32'(qx_reg); mul_b = 32'(qz_reg); end
            OP_QWY: begin mul_a = 32'(qw_reg); mul_b = 32'(qy_reg); end
            OP_QXY: begin mul_a = 32'(qx_reg); mul_b = 32'(qy_reg); end
            OP_QWZ: begin mul_a = 32'(qw_reg); mul_b = 32'(qz_reg); end
            OP_GAIN: begin mul_a = {16'b0, gain_reg}; mul_b = 32'(e_reg); end
            OP_KMAG: begin mul_a = {18'b0, cruise_reg[14:1]}; mul_b = wsc_pkg::INV_GAIN_Q30; end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (tick_go)
                        state_next = S_RCHK;
                    else if (cmd == wsc_pkg::CMD_INTR && flag)
                        state_next = S_EMIT;
                end
            end
            S_RCHK: state_next = S_MUL;
            S_MUL: state_next = S_ACC;
            S_ACC:
            begin
                case (op_reg)
                    OP_RR: state_next = rr_going ? S_MUL : S_EMIT;
                    OP_QWZ: state_next = S_START;
                    OP_GAIN: state_next = S_EMIT;
                    OP_KMAG: state_next = S_START;
                    default: state_next = S_MUL;
                endcase
            end
            S_START: state_next = S_CORD;
            S_CORD:
            begin
                if (cord_done)
                begin
                    case (job_reg)
                        JOB_YAW: state_next = S_START;
                        JOB_BEAR: state_next = S_ERR;
                        default: state_next = S_EMIT;
                    endcase
                end
            end
            S_ERR: state_next = S_DEC;
            S_DEC: state_next = (avoid_on_reg || e_small) ? S_MUL : S_EMIT;
            S_EMIT: state_next = out_free ? S_IDLE : S_EMIT;
            default: state_next = S_IDLE;
        endcase
    end

    assign cord_req.start = (state_reg == S_START);
    assign cord_req.rotate = (job_reg == JOB_POLAR);

    wsc_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cord_req),
        .x_in  (cx_ld_reg),
        .y_in  (cy_ld_reg),
        .z_in  (cz_ld_reg),
        .done  (cord_done),
        .x_out (cord_x),
        .y_out (cord_y),
        .z_out (cord_z)
    );

    // Control state, configuration and stored navigation state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            cruise_reg <= 15'd6144;
            radius_reg <= 31'd13107;
            tol_reg <= 15'd2458;
            spin_reg <= 15'd1638;
            gain_reg <= 16'd4096;
            avmin_reg <= 15'd6210;
            trav_reg <= 8'd0;
            cur_x_reg <= '0;
            cur_y_reg <= '0;
            goal_x_reg <= '0;
            goal_y_reg <= '0;
            qx_reg <= '0;
            qy_reg <= '0;
            qz_reg <= '0;
            qw_reg <= '0;
            avoid_on_reg <= 1'b0;
            avoid_angle_reg <= '0;
            nav_active_reg <= 1'b0;
            pose_seen_reg <= 1'b0;
            goal_seen_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_EMIT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    wsc_pkg::CFG_CRUISE: cruise_reg <= cfg_data[14:0];
                    wsc_pkg::CFG_RADIUS: radius_reg <= cfg_data[30:0];
                    wsc_pkg::CFG_TOL: tol_reg <= cfg_data[14:0];
                    wsc_pkg::CFG_SPIN: spin_reg <= cfg_data[14:0];
                    wsc_pkg::CFG_GAIN: gain_reg <= cfg_data[15:0];
                    wsc_pkg::CFG_AVMIN: avmin_reg <= cfg_data[14:0];
                    wsc_pkg::CFG_TRAV: trav_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end

            if (accept)
            begin
                case (cmd)
                    wsc_pkg::CMD_POSE:
                    begin
                        cur_x_reg <= pos_x;
                        cur_y_reg <= pos_y;
                        qx_reg <= quat_x;
                        qy_reg <= quat_y;
                        qz_reg <= quat_z;
                        qw_reg <= quat_w;
                        pose_seen_reg <= 1'b1;
                    end
                    wsc_pkg::CMD_GOAL:
                    begin
                        if (flag)
                        begin
                            goal_x_reg <= pos_x;
                            goal_y_reg <= pos_y;
                            goal_seen_reg <= 1'b1;
                        end
                        else
                        begin
                            goal_x_reg <= cur_x_reg;
                            goal_y_reg <= cur_y_reg;
                        end
                    end
                    wsc_pkg::CMD_AVOID:
                    begin
                        // An angle of exactly the minimum magnitude leaves everything as is.
                        if (angle_value == 0)
                            avoid_on_reg <= 1'b0;
                        else if (angle_value > 0 && angle_value < mn16)
                        begin
                            avoid_on_reg <= 1'b1;
                            avoid_angle_reg <= mn16;
                        end
                        else if (angle_value < 0 && angle_value > -mn16)
                        begin
                            avoid_on_reg <= 1'b1;
                            avoid_angle_reg <= -mn16;
                        end
                        else if (angle_value > mn16 || angle_value < -mn16)
                        begin
                            avoid_on_reg <= 1'b1;
                            avoid_angle_reg <= angle_value;
                        end
                    end
                    wsc_pkg::CMD_SUPER:
                    begin
                        if (state_code == trav_reg)
                            nav_active_reg <= 1'b1;
                    end
                    wsc_pkg::CMD_INTR: nav_active_reg <= !flag;
                    default: ;
                endcase
            end
        end
    end

    // Sequencer datapath.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ex_reg <= 33'(goal_x_reg) - 33'(cur_x_reg);
                    ey_reg <= 33'(goal_y_reg) - 33'(cur_y_reg);
                    res_vx_reg <= '0;
                    res_vy_reg <= '0;
                    res_w_reg <= '0;
                    res_kind_reg <= wsc_pkg::KIND_STOP;
                end
            end
            S_RCHK:
            begin
                ax_reg <= ax_w;
                ay_reg <= ay_w;
                op_reg <= far ? OP_QXX : OP_AX;
                res_kind_reg <= wsc_pkg::KIND_GOING;
            end
            S_MUL: prod_reg <= mul_a * mul_b;
            S_ACC:
            begin
                op_reg <= op_reg + 1'b1;
                case (op_reg)
                    OP_AX: acc_reg <= pw;
                    OP_AY: acc_reg <= acc_reg + pw;
                    OP_RR:
                    begin
                        if (!rr_going)
                            res_kind_reg <= wsc_pkg::KIND_ARRIVED;
                    end
                    OP_QXX: acc_reg <= pw;
                    OP_QYY:
                    begin
                        acc_reg <= acc_reg + pw;
                        accb_reg <= pw[35:0];
                    end
                    OP_QZZ:
                    begin
                        acc_reg <= acc_reg + pw;
                        accb_reg <= accb_reg + pw[35:0];
                    end
                    OP_QWW:
                    begin
                        acc_reg <= acc_reg + pw;
                        yaw_x_reg <= (acc_reg[wsc_pkg::CW-1:0] + pw[wsc_pkg::CW-1:0])
                                     - (wsc_pkg::CW'(accb_reg) <<< 1);
                    end
                    OP_QXZ: accb_reg <= pw[35:0];
                    OP_QWY:
                    begin
                        accb_reg <= accb_reg - pw[35:0];
                    end
                    OP_QXY:
                    begin
                        // Gimbal lock or a zero quaternion forces yaw to zero.
                        yaw_zero_reg <= (acc_reg == 0) || ({27'b0, g2_abs} >= acc_reg);
                        accb_reg <= pw[35:0];
                    end
                    OP_QWZ:
                    begin
                        if (yaw_zero_reg)
                        begin
                            yaw_reg <= '0;
                            job_reg <= JOB_BEAR;
                            cx_ld_reg <= wsc_pkg::CW'(ex_reg);
                            cy_ld_reg <= wsc_pkg::CW'(ey_reg);
                        end
                        else
                        begin
                            job_reg <= JOB_YAW;
                            cx_ld_reg <= yaw_x_reg;
                            cy_ld_reg <= wsc_pkg::CW'($signed(accb_reg + pw[35:0])) <<< 1;
                        end
                        cz_ld_reg <= '0;
                    end
                    OP_GAIN:
                    begin
                        res_vx_reg <= 16'(cruise_reg);
                        if (w_rnd > 64'sd32767)
                            res_w_reg <= 16'sd32767;
                        else if (w_rnd < -64'sd32768)
                            res_w_reg <= -16'sd32768;
                        else
                            res_w_reg <= w_rnd[15:0];
                    end
                    OP_KMAG:
                    begin
                        job_reg <= JOB_POLAR;
                        cx_ld_reg <= wsc_pkg::CW'(pw >>> 14);
                        cy_ld_reg <= '0;
                    end
                    default: ;
                endcase
            end
            S_CORD:
            begin
                if (cord_done)
                begin
                    case (job_reg)
                        JOB_YAW:
                        begin
                            yaw_reg <= 17'(wsc_pkg::rnd_shift(64'(cord_z), 6'd17));
                            job_reg <= JOB_BEAR;
                            cx_ld_reg <= wsc_pkg::CW'(ex_reg);
                            cy_ld_reg <= wsc_pkg::CW'(ey_reg);
                        end
                        JOB_BEAR:
                            bear_reg <= 17'(wsc_pkg::rnd_shift(64'(cord_z), 6'd17));
                        default:
                        begin
                            res_vx_reg <= flip_reg ? 16'(-x_rnd) : x_rnd[15:0];
                            res_vy_reg <= flip_reg ? 16'(-y_rnd) : y_rnd[15:0];
                            res_w_reg <= '0;
                        end
                    endcase
                end
            end
            S_ERR:
            begin
                if (e_raw > wsc_pkg::PI_Q13)
                    e_reg <= e_raw - wsc_pkg::TWO_PI_Q13;
                else if (e_raw <= -wsc_pkg::PI_Q13)
                    e_reg <= e_raw + wsc_pkg::TWO_PI_Q13;
                else
                    e_reg <= e_raw;
            end
            S_DEC:
            begin
                op_reg <= avoid_on_reg ? OP_KMAG : OP_GAIN;
                res_w_reg <= e_reg[17] ? -16'(spin_reg) : 16'(spin_reg);
                // Fold the crab angle into a half turn and, when it was folded, negate the result afterwards.
                if (pa > wsc_pkg::HALF_PI_Q13)
                begin
                    flip_reg <= 1'b1;
                    cz_ld_reg <= wsc_pkg::ZW'(pa - wsc_pkg::PI_Q13_16) <<< 17;
                end
                else if (pa < -wsc_pkg::HALF_PI_Q13)
                begin
                    flip_reg <= 1'b1;
                    cz_ld_reg <= wsc_pkg::ZW'(pa + wsc_pkg::PI_Q13_16) <<< 17;
                end
                else
                begin
                    flip_reg <= 1'b0;
                    cz_ld_reg <= wsc_pkg::ZW'(pa) <<< 17;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    vel_x_reg <= res_vx_reg;
                    vel_y_reg <= res_vy_reg;
                    turn_reg <= res_w_reg;
                    kind_reg <= res_kind_reg;
                end
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign vel_x = vel_x_reg;
    assign vel_y = vel_y_reg;
    assign turn_rate = turn_reg;
    assign result_kind = kind_reg;

    a_arrived_still: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind == wsc_pkg::KIND_ARRIVED) |->
        (vel_x == 0 && vel_y == 0 && turn_rate == 0))
        else $error("arrival result carries motion");

    a_stop_still: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind == wsc_pkg::KIND_STOP) |->
        (vel_x == 0 && vel_y == 0 && turn_rate == 0))
        else $error("stop result carries motion");

    a_crab_no_turn: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind == wsc_pkg::KIND_GOING && vel_y != 0) |->
        (turn_rate == 0))
        else $error("sideways motion with nonzero turn");

    a_cord_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cord_req.start |=> (state_reg == S_CORD))
        else $error("CORDIC started outside the sequence");

endmodule

FILE: sv/wsc_cordic.sv
// Shared iterative CORDIC: vectoring (atan2 with input normalization) or rotation.
// Depends on wsc_pkg for widths, the arctangent table and the request struct.
module wsc_cordic #(
    parameter int CORDIC_STEPS = wsc_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  wsc_pkg::cord_req_t            req,
    input  logic signed [wsc_pkg::CW-1:0] x_in,
    input  logic signed [wsc_pkg::CW-1:0] y_in,
    input  logic signed [wsc_pkg::ZW-1:0] z_in,
    output logic                          done,
    output logic signed [wsc_pkg::CW-1:0] x_out,
    output logic signed [wsc_pkg::CW-1:0] y_out,
    output logic signed [wsc_pkg::ZW-1:0] z_out
);

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_NORM = 2'd1;
    localparam logic [1:0] C_ITER = 2'd2;
    localparam logic signed [wsc_pkg::CW-1:0] LIM = 44'sd549755813888;
    localparam logic [wsc_pkg::CNT_W-1:0] LAST = wsc_pkg::CNT_W'(CORDIC_STEPS);

    logic [1:0] state_reg;
    logic rotate_reg;
    logic done_reg;
    logic [wsc_pkg::CNT_W-1:0] cnt_reg;
    logic signed [wsc_pkg::CW-1:0] x_reg, y_reg;
    logic signed [wsc_pkg::ZW-1:0] z_reg;
    logic signed [wsc_pkg::CW-1:0] dx, dy;
    logic small_xy, dir_pos;

    assign dx = y_reg >>> cnt_reg;
    assign dy = x_reg >>> cnt_reg;
    assign small_xy = (x_reg < LIM) && (x_reg > -LIM) && (y_reg < LIM) && (y_reg > -LIM);
    assign dir_pos = rotate_reg ? (z_reg >= 0) : (y_reg > 0);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg <= 1'b0;
            rotate_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                C_IDLE:
                begin
                    if (req.start)
                    begin
                        rotate_reg <= req.rotate;
                        cnt_reg <= '0;
                        if (req.rotate)
                            state_reg <= C_ITER;
                        else if (x_in == 0 && y_in == 0)
                            done_reg <= 1'b1;
                        else
                            state_reg <= C_NORM;
                    end
                end
                C_NORM:
                begin
                    if (!small_xy)
                        state_reg <= C_ITER;
                end
                C_ITER:
                begin
                    if (cnt_reg == LAST)
                    begin
                        done_reg <= 1'b1;
                        state_reg <= C_IDLE;
                    end
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            C_IDLE:
            begin
                if (req.start)
                begin
                    x_reg <= x_in;
                    y_reg <= y_in;
                    z_reg <= req.rotate ? z_in : '0;
                end
            end
            C_NORM:
            begin
                if (small_xy)
                begin
                    x_reg <= x_reg <<< 1;
                    y_reg <= y_reg <<< 1;
                end
                else if (x_reg < 0)
                begin
                    // Pre-rotate by a quarter turn into the right half plane.
                    if (y_reg >= 0)
                    begin
                        x_reg <= y_reg;
                        y_reg <= -x_reg;
                        z_reg <= wsc_pkg::HALF_PI_Q30;
                    end
                    else
                    begin
                        x_reg <= -y_reg;
                        y_reg <= x_reg;
                        z_reg <= -wsc_pkg::HALF_PI_Q30;
                    end
                end
            end
            C_ITER:
            begin
                if (cnt_reg != LAST)
                begin
                    if (dir_pos != rotate_reg)
                    begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                    end
                    else
                    begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                    end
                    if (dir_pos)
                        z_reg <= z_reg + (rotate_reg ? -wsc_pkg::atan_q30(cnt_reg)
                                                     : wsc_pkg::atan_q30(cnt_reg));
                    else
                        z_reg <= z_reg + (rotate_reg ? wsc_pkg::atan_q30(cnt_reg)
                                                     : -wsc_pkg::atan_q30(cnt_reg));
                end
            end
            default: ;
        endcase
    end

    assign done = done_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule
